### rtl/vaar_pkg.sv
`default_nettype none
package vaar_pkg;

	// angle input width and angle units (1/64 degree)
	localparam int ANGW        = 16;
	localparam int ANG_FULL    = 23040;
	localparam int ANG_HALF    = 11520;
	localparam int ANG_QUARTER = 5760;

	// unit axis magnitude: unsigned Q1.30, at most 2^30
	localparam int QW  = 31;
	// sine / cosine / one-minus-cosine word, signed Q2.30 with headroom
	localparam int TRW = 34;

	// CORDIC
	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_PER   = 2;
	localparam int CORDIC_STG   = CORDIC_STEPS / CORDIC_PER;

	// axis normalization: front end, square root and divide stages
	localparam int NORM_FRONT = 5;
	localparam int SQRT_STG   = 16;
	localparam int DIV_STG    = 16;
	localparam int NORM_LAT   = NORM_FRONT + SQRT_STG + DIV_STG;

	// sine / cosine: reduce, center, fold, scale, CORDIC, sign
	localparam int SC_LAT  = 4 + CORDIC_STG + 1;
	// Rodrigues datapath
	localparam int ROT_LAT = 8;
	localparam int TOT_LAT = NORM_LAT + ROT_LAT;

	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
	} axis_flags_t;

	typedef struct packed {
		logic signed [TRW-1:0] cs;
		logic signed [TRW-1:0] sn;
		logic signed [TRW-1:0] omc;
	} trig_t;

	typedef struct packed {
		logic zero_axis;
		logic overflow;
	} out_flags_t;

	function automatic logic signed [TRW-1:0] cordic_atan(input int idx);
		case (idx)
			0:       return TRW'(843314857);
			1:       return TRW'(497837829);
			2:       return TRW'(263043837);
			3:       return TRW'(133525159);
			4:       return TRW'(67021687);
			5:       return TRW'(33543516);
			6:       return TRW'(16775851);
			7:       return TRW'(8388437);
			8:       return TRW'(4194283);
			9:       return TRW'(2097149);
			10:      return TRW'(1048576);
			11:      return TRW'(524288);
			12:      return TRW'(262144);
			13:      return TRW'(131072);
			14:      return TRW'(65536);
			15:      return TRW'(32768);
			16:      return TRW'(16384);
			17:      return TRW'(8192);
			18:      return TRW'(4096);
			19:      return TRW'(2048);
			default: return '0;
		endcase
	endfunction

endpackage
`default_nettype wire

### rtl/vaar_in_if.sv
`default_nettype none
interface vaar_in_if import vaar_pkg::*; #(parameter int COMP_WIDTH = 24);
	logic                         valid;
	logic                         ready;
	logic signed [COMP_WIDTH-1:0] vec_x;
	logic signed [COMP_WIDTH-1:0] vec_y;
	logic signed [COMP_WIDTH-1:0] vec_z;
	logic signed [COMP_WIDTH-1:0] axis_x;
	logic signed [COMP_WIDTH-1:0] axis_y;
	logic signed [COMP_WIDTH-1:0] axis_z;
	logic signed [ANGW-1:0]       angle_deg;

	modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg,
		input ready);
	modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg,
		output ready);
endinterface
`default_nettype wire

### rtl/vaar_out_if.sv
`default_nettype none
interface vaar_out_if #(parameter int COMP_WIDTH = 24);
	logic                         valid;
	logic                         ready;
	logic signed [COMP_WIDTH-1:0] rot_x;
	logic signed [COMP_WIDTH-1:0] rot_y;
	logic signed [COMP_WIDTH-1:0] rot_z;
	logic                         zero_axis;
	logic                         overflow;

	modport source (output valid, rot_x, rot_y, rot_z, zero_axis, overflow, input ready);
	modport sink (input valid, rot_x, rot_y, rot_z, zero_axis, overflow, output ready);
endinterface
`default_nettype wire

### rtl/vaar_delay.sv
`default_nettype none
module vaar_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule
`default_nettype wire

### rtl/vaar_norm.sv
`default_nettype none
module vaar_norm import vaar_pkg::*; #(
	parameter int COMP_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [2:0][COMP_WIDTH-1:0]      axis,
	output logic [2:0][QW-1:0]              k_mag,
	output axis_flags_t                     flags
);

	localparam int AXW     = 32;
	localparam int SQW     = 64;
	localparam int ROOTW   = 32;
	localparam int REMW    = 33;
	localparam int DRW     = 33;
	localparam int SQRT_PER = ROOTW / SQRT_STG;
	localparam int DIV_PER  = (QW + DIV_STG - 1) / DIV_STG;

	typedef struct packed {
		logic [SQW-1:0]          sum;
		logic [2:0][AXW-1:0]     am;
		logic [2:0]              neg;
		logic                    zero;
		logic [REMW-1:0]         rem;
		logic [ROOTW-1:0]        root;
	} sqrt_pipe_t;

	typedef struct packed {
		logic [ROOTW-1:0]        len;
		logic [2:0][DRW-1:0]     r;
		logic [2:0][QW-1:0]      q;
		logic [2:0]              neg;
		logic                    zero;
	} div_pipe_t;

	function automatic sqrt_pipe_t sqrt_step(input sqrt_pipe_t s, input logic [1:0] pair);
		logic [REMW+1:0] r2;
		logic [REMW+1:0] trial;
		sqrt_pipe_t      o;
		o     = s;
		r2    = {s.rem, pair};
		trial = {1'b0, s.root, 2'b01};
		if (r2 >= trial) begin
			o.rem  = REMW'(r2 - trial);
			o.root = {s.root[ROOTW-2:0], 1'b1};
		end else begin
			o.rem  = REMW'(r2);
			o.root = {s.root[ROOTW-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic div_pipe_t div_step(input div_pipe_t s);
		logic [DRW-1:0] dv;
		logic [DRW-1:0] t;
		logic           qb;
		div_pipe_t      o;
		o  = s;
		dv = {1'b0, s.len};
		for (int i = 0; i < 3; i++) begin
			qb        = (s.r[i] >= dv);
			t         = qb ? (s.r[i] - dv) : s.r[i];
			o.r[i]    = {t[DRW-2:0], 1'b0};
			o.q[i]    = {s.q[i][QW-2:0], qb};
		end
		return o;
	endfunction

	// stage 1: magnitudes and largest magnitude
	logic [2:0][COMP_WIDTH-1:0] mag_c;
	logic [COMP_WIDTH-1:0]      m01_c;
	logic [COMP_WIDTH-1:0]      max_c;
	logic [2:0][COMP_WIDTH-1:0] mag_s1;
	logic [COMP_WIDTH-1:0]      max_s1;
	logic [2:0]                 neg_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = axis[i][COMP_WIDTH-1] ? COMP_WIDTH'(~axis[i] + 1'b1) : axis[i];
		end
		m01_c = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
		max_c = (m01_c > mag_c[2]) ? m01_c : mag_c[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
			max_s1 <= max_c;
			neg_s1 <= {axis[2][COMP_WIDTH-1], axis[1][COMP_WIDTH-1], axis[0][COMP_WIDTH-1]};
		end
	end

	// stage 2: shift that brings the largest magnitude into [2^30, 2^31)
	logic [AXW-1:0]             m32_c;
	logic [4:0]                 msb_c;
	logic [4:0]                 sh_c;
	logic [4:0]                 sh_s2;
	logic [2:0][COMP_WIDTH-1:0] mag_s2;
	logic [2:0]                 neg_s2;
	logic                       zero_s2;

	always_comb begin
		m32_c = AXW'(max_s1);
		msb_c = '0;
		for (int b = 0; b < AXW - 1; b++) begin
			if (m32_c[b]) msb_c = 5'(b);
		end
		sh_c = m32_c[AXW-1] ? 5'd0 : (5'd30 - msb_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s2   <= sh_c;
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= (max_s1 == '0);
		end
	end

	// stage 3: scale, stage 4: square, stage 5: sum of squares
	logic [2:0][AXW-1:0] am_s3;
	logic [2:0]          neg_s3;
	logic                zero_s3;
	logic [2:0][SQW-1:0] sq_s4;
	logic [2:0][AXW-1:0] am_s4;
	logic [2:0]          neg_s4;
	logic                zero_s4;
	sqrt_pipe_t          sqin_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				am_s3[i] <= AXW'(mag_s2[i]) << sh_s2;
				sq_s4[i] <= SQW'(am_s3[i]) * SQW'(am_s3[i]);
			end
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			am_s4   <= am_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			sqin_s5.sum  <= sq_s4[0] + sq_s4[1] + sq_s4[2];
			sqin_s5.am   <= am_s4;
			sqin_s5.neg  <= neg_s4;
			sqin_s5.zero <= zero_s4;
			sqin_s5.rem  <= '0;
			sqin_s5.root <= '0;
		end
	end

	// square root, two result bits per stage
	sqrt_pipe_t sqrt_s [SQRT_STG];

	for (genvar g = 0; g < SQRT_STG; g++) begin : g_sqrt
		sqrt_pipe_t st_in;
		sqrt_pipe_t st_out;
		if (g == 0) begin : g_first
			assign st_in = sqin_s5;
		end else begin : g_next
			assign st_in = sqrt_s[g-1];
		end
		always_comb begin
			st_out = st_in;
			for (int j = 0; j < SQRT_PER; j++) begin
				st_out = sqrt_step(st_out,
					st_in.sum[SQW-1-2*(g*SQRT_PER+j) -: 2]);
			end
		end
		always_ff @(posedge clk) begin
			if (en) sqrt_s[g] <= st_out;
		end
	end

	// unit axis: magnitude * 2^30 / length, two quotient bits per stage, one in the last
	div_pipe_t div_s [DIV_STG];
	div_pipe_t div_in;

	always_comb begin
		div_in.len  = sqrt_s[SQRT_STG-1].root;
		div_in.neg  = sqrt_s[SQRT_STG-1].neg;
		div_in.zero = sqrt_s[SQRT_STG-1].zero;
		div_in.q    = '0;
		for (int i = 0; i < 3; i++) begin
			div_in.r[i] = DRW'(sqrt_s[SQRT_STG-1].am[i]);
		end
	end

	for (genvar g = 0; g < DIV_STG; g++) begin : g_div
		div_pipe_t dv_in;
		div_pipe_t dv_out;
		if (g == 0) begin : g_first
			assign dv_in = div_in;
		end else begin : g_next
			assign dv_in = div_s[g-1];
		end
		always_comb begin
			dv_out = dv_in;
			for (int j = 0; j < DIV_PER; j++) begin
				if (g * DIV_PER + j < QW) dv_out = div_step(dv_out);
			end
		end
		always_ff @(posedge clk) begin
			if (en) div_s[g] <= dv_out;
		end
	end

	assign k_mag      = div_s[DIV_STG-1].q;
	assign flags.neg  = div_s[DIV_STG-1].neg;
	assign flags.zero = div_s[DIV_STG-1].zero;

endmodule
`default_nettype wire

### rtl/vaar_sincos.sv
`default_nettype none
module vaar_sincos import vaar_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [ANGW-1:0] angle,
	output trig_t                  trig
);

	localparam int AW = ANGW + 1;
	localparam int RAD_PER_UNIT_Q30 = 292818;
	localparam int CORDIC_GAIN_Q30  = 652032874;
	localparam int ONE_Q30          = 1073741824;

	typedef struct packed {
		logic signed [TRW-1:0] x;
		logic signed [TRW-1:0] y;
		logic signed [TRW-1:0] z;
		logic                  neg;
	} cordic_t;

	function automatic cordic_t cordic_step(input cordic_t s, input int i);
		logic signed [TRW-1:0] dx;
		logic signed [TRW-1:0] dy;
		cordic_t               o;
		o  = s;
		dx = s.y >>> i;
		dy = s.x >>> i;
		if (s.z >= 0) begin
			o.x = s.x - dx;
			o.y = s.y + dy;
			o.z = s.z - cordic_atan(i);
		end else begin
			o.x = s.x + dx;
			o.y = s.y - dy;
			o.z = s.z + cordic_atan(i);
		end
		return o;
	endfunction

	logic signed [AW-1:0]  u_c;
	logic signed [AW-1:0]  r_s1;
	logic signed [AW-1:0]  a_s2;
	logic signed [AW-1:0]  a_s3;
	logic                  neg_s3;
	cordic_t               cin_s4;

	assign u_c = AW'(angle);

	always_ff @(posedge clk) begin
		if (en) begin
			// reduce modulo a full turn, keeping the sign of the angle
			if (u_c >= ANG_FULL) r_s1 <= AW'(u_c - ANG_FULL);
			else if (u_c <= -ANG_FULL) r_s1 <= AW'(u_c + ANG_FULL);
			else r_s1 <= u_c;

			// center into (-half, +half]
			if (r_s1 <= -ANG_HALF) a_s2 <= AW'(r_s1 + ANG_FULL);
			else if (r_s1 > ANG_HALF) a_s2 <= AW'(r_s1 - ANG_FULL);
			else a_s2 <= r_s1;

			// fold into -quarter..+quarter, flip cosine sign
			if (a_s2 > ANG_QUARTER) begin
				a_s3   <= AW'(ANG_HALF - a_s2);
				neg_s3 <= 1'b1;
			end else if (a_s2 < -ANG_QUARTER) begin
				a_s3   <= AW'(-ANG_HALF - a_s2);
				neg_s3 <= 1'b1;
			end else begin
				a_s3   <= a_s2;
				neg_s3 <= 1'b0;
			end

			// radians in Q2.30
			cin_s4.z   <= TRW'(a_s3) * TRW'(RAD_PER_UNIT_Q30);
			cin_s4.x   <= TRW'(CORDIC_GAIN_Q30);
			cin_s4.y   <= '0;
			cin_s4.neg <= neg_s3;
		end
	end

	cordic_t cor_s [CORDIC_STG];

	for (genvar g = 0; g < CORDIC_STG; g++) begin : g_cordic
		cordic_t c_in;
		cordic_t c_out;
		if (g == 0) begin : g_first
			assign c_in = cin_s4;
		end else begin : g_next
			assign c_in = cor_s[g-1];
		end
		always_comb begin
			c_out = c_in;
			for (int j = 0; j < CORDIC_PER; j++) begin
				c_out = cordic_step(c_out, g * CORDIC_PER + j);
			end
		end
		always_ff @(posedge clk) begin
			if (en) cor_s[g] <= c_out;
		end
	end

	trig_t   trig_q;
	cordic_t cl;

	assign cl = cor_s[CORDIC_STG-1];

	always_ff @(posedge clk) begin
		if (en) begin
			trig_q.cs  <= cl.neg ? -cl.x : cl.x;
			trig_q.omc <= cl.neg ? (TRW'(ONE_Q30) + cl.x) : (TRW'(ONE_Q30) - cl.x);
			trig_q.sn  <= cl.y;
		end
	end

	assign trig = trig_q;

endmodule
`default_nettype wire

### rtl/vaar_rodr.sv
`default_nettype none
module vaar_rodr import vaar_pkg::*; #(
	parameter int COMP_WIDTH = 24
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [2:0][COMP_WIDTH-1:0] vec,
	input  logic [2:0][QW-1:0]         k_mag,
	input  axis_flags_t                flags,
	input  trig_t                      trig,
	output logic [2:0][COMP_WIDTH-1:0] rot,
	output out_flags_t                 status
);

	localparam int KW  = QW + 1;
	localparam int PW  = COMP_WIDTH + KW;
	localparam int VCW = COMP_WIDTH + TRW;
	localparam int MW  = 72;
	localparam int DW  = 36;
	localparam int SW  = 40;
	localparam int RW  = SW + 2;
	localparam logic signed [RW-1:0] SAT_HI = RW'({(COMP_WIDTH-1){1'b1}});
	localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

	function automatic logic signed [MW-1:0] rnd30(input logic signed [MW-1:0] x);
		return (x + MW'(64'sd536870912)) >>> 30;
	endfunction

	// r1: signed unit axis
	logic signed [KW-1:0]         k_s1 [3];
	logic [2:0][COMP_WIDTH-1:0]   vec_s1;
	trig_t                        trig_s1;
	logic                         zero_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				k_s1[i] <= flags.neg[i] ? -$signed(KW'({1'b0, k_mag[i]}))
					: $signed(KW'({1'b0, k_mag[i]}));
			end
			vec_s1  <= vec;
			trig_s1 <= trig;
			zero_s1 <= flags.zero;
		end
	end

	// r2: all v_i * k_j and v_i * cos
	logic signed [PW-1:0]         pk_s2 [3][3];
	logic signed [VCW-1:0]        vc_s2 [3];
	logic signed [KW-1:0]         k_s2 [3];
	logic [2:0][COMP_WIDTH-1:0]   vec_s2;
	logic signed [TRW-1:0]        sn_s2;
	logic signed [TRW-1:0]        omc_s2;
	logic                         zero_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pk_s2[i][j] <= PW'($signed(vec_s1[i])) * PW'(k_s1[j]);
				end
				vc_s2[i] <= VCW'($signed(vec_s1[i])) * VCW'(trig_s1.cs);
				k_s2[i]  <= k_s1[i];
			end
			vec_s2  <= vec_s1;
			sn_s2   <= trig_s1.sn;
			omc_s2  <= trig_s1.omc;
			zero_s2 <= zero_s1;
		end
	end

	// r3: rounded dot product, cross product and v*cos
	logic signed [DW-1:0]         d_s3;
	logic signed [DW-1:0]         cr_s3 [3];
	logic signed [SW-1:0]         vcr_s3 [3];
	logic signed [KW-1:0]         k_s3 [3];
	logic [2:0][COMP_WIDTH-1:0]   vec_s3;
	logic signed [TRW-1:0]        sn_s3;
	logic signed [TRW-1:0]        omc_s3;
	logic                         zero_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= DW'(rnd30(MW'(pk_s2[0][0]) + MW'(pk_s2[1][1]) + MW'(pk_s2[2][2])));
			cr_s3[0] <= DW'(rnd30(MW'(pk_s2[1][2]) - MW'(pk_s2[2][1])));
			cr_s3[1] <= DW'(rnd30(MW'(pk_s2[2][0]) - MW'(pk_s2[0][2])));
			cr_s3[2] <= DW'(rnd30(MW'(pk_s2[0][1]) - MW'(pk_s2[1][0])));
			for (int i = 0; i < 3; i++) begin
				vcr_s3[i] <= SW'(rnd30(MW'(vc_s2[i])));
				k_s3[i]   <= k_s2[i];
			end
			vec_s3  <= vec_s2;
			sn_s3   <= sn_s2;
			omc_s3  <= omc_s2;
			zero_s3 <= zero_s2;
		end
	end

	// r4: d*(1-cos) and cross*sin
	logic signed [MW-1:0]         dm_s4;
	logic signed [MW-1:0]         cs_s4 [3];
	logic signed [SW-1:0]         vcr_s4 [3];
	logic signed [KW-1:0]         k_s4 [3];
	logic [2:0][COMP_WIDTH-1:0]   vec_s4;
	logic                         zero_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			dm_s4 <= MW'(d_s3) * MW'(omc_s3);
			for (int i = 0; i < 3; i++) begin
				cs_s4[i]  <= MW'(cr_s3[i]) * MW'(sn_s3);
				vcr_s4[i] <= vcr_s3[i];
				k_s4[i]   <= k_s3[i];
			end
			vec_s4  <= vec_s3;
			zero_s4 <= zero_s3;
		end
	end

	// r5: round both
	logic signed [DW-1:0]         t3_s5;
	logic signed [SW-1:0]         crs_s5 [3];
	logic signed [SW-1:0]         vcr_s5 [3];
	logic signed [KW-1:0]         k_s5 [3];
	logic [2:0][COMP_WIDTH-1:0]   vec_s5;
	logic                         zero_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			t3_s5 <= DW'(rnd30(dm_s4));
			for (int i = 0; i < 3; i++) begin
				crs_s5[i] <= SW'(rnd30(cs_s4[i]));
				vcr_s5[i] <= vcr_s4[i];
				k_s5[i]   <= k_s4[i];
			end
			vec_s5  <= vec_s4;
			zero_s5 <= zero_s4;
		end
	end

	// r6: k * t3, r7: round
	logic signed [MW-1:0]         ktp_s6 [3];
	logic signed [SW-1:0]         crs_s6 [3];
	logic signed [SW-1:0]         vcr_s6 [3];
	logic [2:0][COMP_WIDTH-1:0]   vec_s6;
	logic                         zero_s6;
	logic signed [SW-1:0]         kt_s7 [3];
	logic signed [SW-1:0]         crs_s7 [3];
	logic signed [SW-1:0]         vcr_s7 [3];
	logic [2:0][COMP_WIDTH-1:0]   vec_s7;
	logic                         zero_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ktp_s6[i] <= MW'(k_s5[i]) * MW'(t3_s5);
				crs_s6[i] <= crs_s5[i];
				vcr_s6[i] <= vcr_s5[i];
				kt_s7[i]  <= SW'(rnd30(ktp_s6[i]));
				crs_s7[i] <= crs_s6[i];
				vcr_s7[i] <= vcr_s6[i];
			end
			vec_s6  <= vec_s5;
			zero_s6 <= zero_s5;
			vec_s7  <= vec_s6;
			zero_s7 <= zero_s6;
		end
	end

	// r8: sum, saturate, zero-axis bypass
	logic signed [RW-1:0]         sum_c [3];
	logic [2:0][COMP_WIDTH-1:0]   rot_c;
	logic [2:0]                   sat_c;
	logic [2:0][COMP_WIDTH-1:0]   rot_s8;
	out_flags_t                   status_s8;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = RW'(vcr_s7[i]) + RW'(crs_s7[i]) + RW'(kt_s7[i]);
			if (sum_c[i] > SAT_HI) begin
				rot_c[i] = SAT_HI[COMP_WIDTH-1:0];
				sat_c[i] = 1'b1;
			end else if (sum_c[i] < SAT_LO) begin
				rot_c[i] = SAT_LO[COMP_WIDTH-1:0];
				sat_c[i] = 1'b1;
			end else begin
				rot_c[i] = sum_c[i][COMP_WIDTH-1:0];
				sat_c[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s8             <= zero_s7 ? vec_s7 : rot_c;
			status_s8.zero_axis <= zero_s7;
			status_s8.overflow  <= ~zero_s7 & (|sat_c);
		end
	end

	assign rot    = rot_s8;
	assign status = status_s8;

endmodule
`default_nettype wire

### rtl/vector_axis_angle_rotation.sv
// Axis-angle vector rotation (Rodrigues' formula), fully pipelined.
//
// Input channel vec_in carries one beat per vector: vec_x/y/z, axis_x/y/z
// (signed Q12.12, axis of any length) and angle_deg in 1/64 degree. Output
// channel rot_out returns one beat per input beat, in order: the rotated
// vector rot_x/y/z (saturated), zero_axis and overflow. A zero axis passes
// the vector through with zero_axis set.
//
// Throughput: one beat per cycle unless the skid register holds a beat. An
// input beat passes through 37 normalization stages (magnitude, shift,
// scale, square, sum, 16 square-root stages, 16 divide stages), 8 rotation
// stages and one output register. The sine/cosine unit (15 stages, 10 of
// them CORDIC) runs alongside the normalization.
//
// The whole pipeline advances together. A skid register beside the output
// register absorbs one beat when the receiver stalls; while it holds a beat
// the pipeline freezes and vec_in.ready is low. Nothing is dropped or
// repeated. Reset clears all valid bits; no clearing pass is needed.
`default_nettype none
module vector_axis_angle_rotation import vaar_pkg::*; #(
	parameter int COMP_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	vaar_in_if.sink     vec_in,
	vaar_out_if.source  rot_out
);

	logic                       en;
	logic [TOT_LAT-1:0]         vld_q;
	logic                       pipe_vld;

	logic [2:0][COMP_WIDTH-1:0] axis_in;
	logic [2:0][COMP_WIDTH-1:0] vec_pk;
	logic [2:0][COMP_WIDTH-1:0] vec_dly;
	logic [ANGW-1:0]            ang_dly;
	logic [2:0][QW-1:0]         k_mag;
	axis_flags_t                aflags;
	trig_t                      trig;
	logic [2:0][COMP_WIDTH-1:0] res_rot;
	out_flags_t                 res_flags;

	logic                       out_v_q;
	logic [2:0][COMP_WIDTH-1:0] out_rot_q;
	out_flags_t                 out_flags_q;
	logic                       skid_v_q;
	logic [2:0][COMP_WIDTH-1:0] skid_rot_q;
	out_flags_t                 skid_flags_q;

	// advance whenever the skid is free
	assign en           = ~skid_v_q;
	assign vec_in.ready = en;
	assign pipe_vld     = vld_q[TOT_LAT-1];

	assign axis_in = {vec_in.axis_z, vec_in.axis_y, vec_in.axis_x};
	assign vec_pk  = {vec_in.vec_z, vec_in.vec_y, vec_in.vec_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT_LAT-2:0], vec_in.valid};
		end
	end

	vaar_norm #(.COMP_WIDTH(COMP_WIDTH)) u_norm (
		.clk   (clk),
		.en    (en),
		.axis  (axis_in),
		.k_mag (k_mag),
		.flags (aflags)
	);

	// hold the vector until the unit axis is ready
	vaar_delay #(.WIDTH(3 * COMP_WIDTH), .DEPTH(NORM_LAT)) u_vec_dly (
		.clk  (clk),
		.en   (en),
		.din  (vec_pk),
		.dout (vec_dly)
	);

	// start the angle late so sine/cosine meet the unit axis
	vaar_delay #(.WIDTH(ANGW), .DEPTH(NORM_LAT - SC_LAT)) u_ang_dly (
		.clk  (clk),
		.en   (en),
		.din  (vec_in.angle_deg),
		.dout (ang_dly)
	);

	vaar_sincos u_sincos (
		.clk   (clk),
		.en    (en),
		.angle ($signed(ang_dly)),
		.trig  (trig)
	);

	vaar_rodr #(.COMP_WIDTH(COMP_WIDTH)) u_rodr (
		.clk    (clk),
		.en     (en),
		.vec    (vec_dly),
		.k_mag  (k_mag),
		.flags  (aflags),
		.trig   (trig),
		.rot    (res_rot),
		.status (res_flags)
	);

	// output register plus one-beat skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || rot_out.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= pipe_vld;
			end
		end else if (pipe_vld && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || rot_out.ready) begin
			if (skid_v_q) begin
				out_rot_q   <= skid_rot_q;
				out_flags_q <= skid_flags_q;
			end else begin
				out_rot_q   <= res_rot;
				out_flags_q <= res_flags;
			end
		end else if (pipe_vld && en) begin
			skid_rot_q   <= res_rot;
			skid_flags_q <= res_flags;
		end
	end

	assign rot_out.valid     = out_v_q;
	assign rot_out.rot_x     = out_rot_q[0];
	assign rot_out.rot_y     = out_rot_q[1];
	assign rot_out.rot_z     = out_rot_q[2];
	assign rot_out.zero_axis = out_flags_q.zero_axis;
	assign rot_out.overflow  = out_flags_q.overflow;

endmodule
`default_nettype wire
